// ===== hdl/led_effect_animator_defines.svh =====
// Assertion macros shared by the LED effect animator RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LED_EFFECT_ANIMATOR_DEFINES_SVH
`define LED_EFFECT_ANIMATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LEA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lea_pkg.sv =====
// Package for the LED effect animator: payload structs, codes, pattern tables
// and the small constant-divisor scaler. No dependencies.
`timescale 1ns / 1ps

package lea_pkg;

    localparam logic       REQ_START = 1'b0;
    localparam logic       REQ_TICK  = 1'b1;

    localparam logic [1:0] EFFECT_RIPPLE = 2'd0;
    localparam logic [1:0] EFFECT_FLOW   = 2'd1;
    localparam logic [1:0] EFFECT_PULSE  = 2'd2;
    localparam logic [1:0] EFFECT_NONE   = 2'd3;

    localparam logic [2:0] NPIX     = 3'd5;
    localparam logic [2:0] LAST_PIX = 3'd4;
    localparam logic [2:0] MID_PIX  = 3'd2;

    // Flow and pulse levels are in twelfths.
    localparam logic [3:0] DEN_TWELFTHS = 4'd12;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ms;
        logic        enable;
        logic [1:0]  effect;
        logic        to_right;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] span_ms;
        logic [15:0] interval_ms;
    } req_t;

    typedef struct packed {
        logic [2:0] pixel_index;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last;
    } pix_t;

    // Reduce a value below ten modulo five.
    function automatic logic [2:0] mod5_small(input logic [3:0] s);
        logic [3:0] r;
        r = (s >= 4'd5) ? (s - 4'd5) : s;
        return r[2:0];
    endfunction

    // Ripple denominators per phase and pixel, numerator one; zero is black.
    function automatic logic [3:0] ripple_den(input logic [1:0] ph, input logic [2:0] pix);
        logic [3:0] d;
        d = 4'd0;
        case (ph)
            2'd0:
            begin
                case (pix)
                    3'd1, 3'd3: d = 4'd5;
                    3'd2:       d = 4'd1;
                    default:    d = 4'd0;
                endcase
            end
            2'd1:
            begin
                case (pix)
                    3'd0, 3'd4: d = 4'd4;
                    3'd1, 3'd3: d = 4'd1;
                    3'd2:       d = 4'd2;
                    default:    d = 4'd0;
                endcase
            end
            2'd2:
            begin
                case (pix)
                    3'd0, 3'd4: d = 4'd1;
                    3'd1, 3'd3: d = 4'd4;
                    default:    d = 4'd0;
                endcase
            end
            default:
            begin
                case (pix)
                    3'd0, 3'd4: d = 4'd4;
                    3'd1, 3'd3: d = 4'd6;
                    3'd2:       d = 4'd8;
                    default:    d = 4'd0;
                endcase
            end
        endcase
        return d;
    endfunction

    function automatic logic [3:0] flow_num(input logic [2:0] gap);
        logic [3:0] n;
        case (gap)
            3'd0:    n = 4'd12;
            3'd1:    n = 4'd7;
            3'd2:    n = 4'd4;
            3'd3:    n = 4'd2;
            3'd4:    n = 4'd1;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] pulse_num(input logic [2:0] idx);
        logic [3:0] n;
        case (idx)
            3'd0:    n = 4'd5;
            3'd1:    n = 4'd12;
            3'd2:    n = 4'd7;
            3'd3:    n = 4'd3;
            3'd4:    n = 4'd1;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Side pixels of the pulse: floor(2n/3) of the centre level.
    function automatic logic [3:0] pulse_side(input logic [2:0] idx);
        logic [3:0] n;
        case (idx)
            3'd0:    n = 4'd3;
            3'd1:    n = 4'd8;
            3'd2:    n = 4'd4;
            3'd3:    n = 4'd2;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // floor(prod / den) for the denominators in use; zero gives black.
    // Divide by 5 and by 3 through a reciprocal, exact for these ranges.
    function automatic logic [7:0] scale_div(input logic [11:0] prod, input logic [3:0] den);
        logic [11:0] opnd;
        logic [12:0] recip;
        logic [24:0] mul;
        logic [7:0]  res;
        case (den)
            4'd5:    opnd = prod;
            4'd6:    opnd = {1'b0, prod[11:1]};
            default: opnd = {2'b00, prod[11:2]};
        endcase
        recip = (den == 4'd5) ? 13'd3277 : 13'd5462;
        mul   = {13'd0, opnd} * {12'd0, recip};
        case (den)
            4'd1:          res = prod[7:0];
            4'd2:          res = prod[8:1];
            4'd4:          res = prod[9:2];
            4'd8:          res = prod[10:3];
            4'd5, 4'd6,
            4'd12:         res = mul[21:14];
            default:       res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/led_effect_animator.sv =====
// A start transaction only loads the effect state. A tick that blanks goes to the
// pixel loop; a tick that renders first runs the bit-serial frame division and a
// frame check. The pixel loop holds while the pixel output is stalled.
// One request at a time: the next is accepted when the current frame has left
// the sequencer; the last pixel may still wait in the output register.
// Reset: asynchronous, idle, effect none, not running, last frame marked unseen.
`timescale 1ns / 1ps
`include "led_effect_animator_defines.svh"

module led_effect_animator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  lea_pkg::req_t   req_data,
    output logic            pix_valid,
    input  logic            pix_stall,
    output lea_pkg::pix_t   pix_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // control and effect state
    logic [2:0]  state_reg,      state_next;
    logic        running_reg,    running_next;
    logic        blank_done_reg, blank_done_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [15:0] last_frame_reg, last_frame_next;
    logic        lf_valid_reg,   lf_valid_next;
    logic [1:0]  kind_reg,       kind_next;
    logic        flow_right_reg, flow_right_next;
    logic [7:0]  red_reg,        red_next;
    logic [7:0]  green_reg,      green_next;
    logic [7:0]  blue_reg,       blue_next;
    logic [15:0] total_reg,      total_next;
    logic [15:0] period_reg,     period_next;
    logic        black_reg,      black_next;
    logic [3:0]  div_cnt_reg,    div_cnt_next;
    logic [2:0]  pix_cnt_reg,    pix_cnt_next;
    logic [2:0]  m5_reg,         m5_next;
    logic        pix_valid_reg,  pix_valid_next;

    // datapath
    logic [15:0] quo_reg,   quo_next;
    logic [15:0] rem_reg,   rem_next;
    logic [11:0] prod_r_reg, prod_r_next;
    logic [11:0] prod_g_reg, prod_g_next;
    logic [11:0] prod_b_reg, prod_b_next;
    logic [3:0]  den_reg,   den_next;
    lea_pkg::pix_t pix_data_reg, pix_data_next;

    logic        accept;
    logic        load_out;
    logic [31:0] elapsed;
    logic        ended;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        qbit;
    logic [3:0]  num;
    logic [3:0]  den;
    logic [3:0]  dist_sum;
    logic [2:0]  tail_pos;

    // terms for the checks at the end
    logic        cfg_ok;
    logic        live_tick;
    logic        frame_end;
    logic        frame_closed;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign load_out  = (state_reg == S_OUT) && (!pix_valid_reg || !pix_stall);
    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_data_reg;

    assign elapsed = req_data.now_ms - start_time_reg;
    assign ended   = (elapsed[31:16] != 16'd0) || (elapsed[15:0] >= total_reg);

    // one restoring division step: bring down the next dividend bit
    assign trial = {rem_reg, quo_reg[15]};
    assign diff  = trial - {1'b0, period_reg};
    assign qbit  = !diff[16];

    // pixel level for the current pixel
    always_comb
    begin
        num      = 4'd0;
        den      = 4'd0;
        dist_sum = 4'd0;
        if (flow_right_reg)
        begin
            dist_sum = {1'b0, m5_reg} + 4'd5 - {1'b0, pix_cnt_reg};
        end
        else
        begin
            dist_sum = {1'b0, pix_cnt_reg} + {1'b0, m5_reg} + 4'd1;
        end
        tail_pos = lea_pkg::mod5_small(dist_sum);
        if (!black_reg)
        begin
            case (kind_reg)
                lea_pkg::EFFECT_RIPPLE:
                begin
                    num = 4'd1;
                    den = lea_pkg::ripple_den(last_frame_reg[1:0], pix_cnt_reg);
                end
                lea_pkg::EFFECT_FLOW:
                begin
                    num = lea_pkg::flow_num(tail_pos);
                    den = lea_pkg::DEN_TWELFTHS;
                end
                lea_pkg::EFFECT_PULSE:
                begin
                    num = (pix_cnt_reg == lea_pkg::MID_PIX) ? lea_pkg::pulse_num(m5_reg)
                                                            : lea_pkg::pulse_side(m5_reg);
                    den = lea_pkg::DEN_TWELFTHS;
                end
                default:
                begin
                    num = 4'd0;
                    den = 4'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        blank_done_next = blank_done_reg;
        start_time_next = start_time_reg;
        last_frame_next = last_frame_reg;
        lf_valid_next   = lf_valid_reg;
        kind_next       = kind_reg;
        flow_right_next = flow_right_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        total_next      = total_reg;
        period_next     = period_reg;
        black_next      = black_reg;
        div_cnt_next    = div_cnt_reg;
        pix_cnt_next    = pix_cnt_reg;
        m5_next         = m5_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        prod_r_next     = prod_r_reg;
        prod_g_next     = prod_g_reg;
        prod_b_next     = prod_b_reg;
        den_next        = den_reg;
        pix_data_next   = pix_data_reg;
        pix_valid_next  = pix_valid_reg;

        if (load_out)
        begin
            pix_valid_next = 1'b1;
        end
        else if (!pix_stall)
        begin
            pix_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_data.req_type == lea_pkg::REQ_START)
                    begin
                        kind_next       = req_data.effect;
                        flow_right_next = req_data.to_right;
                        red_next        = req_data.red;
                        green_next      = req_data.green;
                        blue_next       = req_data.blue;
                        total_next      = req_data.span_ms;
                        period_next     = req_data.interval_ms;
                        start_time_next = req_data.now_ms;
                        lf_valid_next   = 1'b0;
                        blank_done_next = 1'b0;
                        running_next    = req_data.enable && (req_data.interval_ms != 16'd0)
                                          && (req_data.span_ms != 16'd0);
                    end
                    else if (!running_reg)
                    begin
                        if (!blank_done_reg)
                        begin
                            blank_done_next = 1'b1;
                            black_next      = 1'b1;
                            pix_cnt_next    = 3'd0;
                            state_next      = S_MUL;
                        end
                    end
                    else if (ended)
                    begin
                        running_next    = 1'b0;
                        blank_done_next = 1'b1;
                        black_next      = 1'b1;
                        pix_cnt_next    = 3'd0;
                        state_next      = S_MUL;
                    end
                    else
                    begin
                        // elapsed fits 16 bits here since it is below the duration
                        quo_next     = elapsed[15:0];
                        rem_next     = 16'd0;
                        m5_next      = 3'd0;
                        div_cnt_next = 4'd15;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = qbit ? diff[15:0] : trial[15:0];
                quo_next = {quo_reg[14:0], qbit};
                // track the quotient modulo five as its bits arrive
                m5_next  = lea_pkg::mod5_small({m5_reg, qbit});
                div_cnt_next = div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd0)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (lf_valid_reg && (quo_reg == last_frame_reg))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    last_frame_next = quo_reg;
                    lf_valid_next   = 1'b1;
                    black_next      = (kind_reg == lea_pkg::EFFECT_NONE);
                    pix_cnt_next    = 3'd0;
                    state_next      = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_r_next = {4'd0, red_reg}   * {8'd0, num};
                prod_g_next = {4'd0, green_reg} * {8'd0, num};
                prod_b_next = {4'd0, blue_reg}  * {8'd0, num};
                den_next    = den;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    pix_data_next.pixel_index = pix_cnt_reg;
                    pix_data_next.out_red     = lea_pkg::scale_div(prod_r_reg, den_reg);
                    pix_data_next.out_green   = lea_pkg::scale_div(prod_g_reg, den_reg);
                    pix_data_next.out_blue    = lea_pkg::scale_div(prod_b_reg, den_reg);
                    pix_data_next.last        = (pix_cnt_reg == lea_pkg::LAST_PIX);
                    if (pix_cnt_reg == lea_pkg::LAST_PIX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pix_cnt_next = pix_cnt_reg + 3'd1;
                        state_next   = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            running_reg    <= 1'b0;
            blank_done_reg <= 1'b0;
            start_time_reg <= 32'd0;
            last_frame_reg <= 16'hFFFF;
            lf_valid_reg   <= 1'b0;
            kind_reg       <= lea_pkg::EFFECT_NONE;
            flow_right_reg <= 1'b0;
            red_reg        <= 8'd0;
            green_reg      <= 8'd0;
            blue_reg       <= 8'd0;
            total_reg      <= 16'd0;
            period_reg     <= 16'd0;
            black_reg      <= 1'b0;
            div_cnt_reg    <= 4'd0;
            pix_cnt_reg    <= 3'd0;
            m5_reg         <= 3'd0;
            pix_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            blank_done_reg <= blank_done_next;
            start_time_reg <= start_time_next;
            last_frame_reg <= last_frame_next;
            lf_valid_reg   <= lf_valid_next;
            kind_reg       <= kind_next;
            flow_right_reg <= flow_right_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
            total_reg      <= total_next;
            period_reg     <= period_next;
            black_reg      <= black_next;
            div_cnt_reg    <= div_cnt_next;
            pix_cnt_reg    <= pix_cnt_next;
            m5_reg         <= m5_next;
            pix_valid_reg  <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        prod_r_reg   <= prod_r_next;
        prod_g_reg   <= prod_g_next;
        prod_b_reg   <= prod_b_next;
        den_reg      <= den_next;
        pix_data_reg <= pix_data_next;
    end

    assign cfg_ok       = (period_reg != 16'd0) && (total_reg != 16'd0);
    assign live_tick    = accept && (req_data.req_type == lea_pkg::REQ_TICK) && running_reg
                          && !ended;
    assign frame_end    = load_out && (pix_cnt_reg == lea_pkg::LAST_PIX);
    assign frame_closed = (state_reg == S_IDLE) && pix_valid && pix_data.last;

    `LEA_ASSERT_NOW(a_run_cfg, running_reg, cfg_ok, "running with zero interval or duration")
    `LEA_ASSERT_NOW(a_run_blank, running_reg, !blank_done_reg, "running and blank done both set")
    `LEA_ASSERT_NEXT(a_tick_div, live_tick, state_reg == S_DIV, "tick did not start division")
    `LEA_ASSERT_NEXT(a_last_pix, frame_end, frame_closed, "frame did not close on last pixel")

endmodule

// ===== test/led_effect_animator_tb.sv =====
// Self-checking testbench for led_effect_animator: queue-fed request driver,
// pixel monitor and a frame predictor kept in step with each request.
// Depends on lea_pkg and the led_effect_animator RTL.
`timescale 1ns / 1ps

module led_effect_animator_tb;

    // Level tables packed as nibbles, lowest index in the lowest nibble.
    localparam logic [79:0] RIPPLE_DEN  = 80'h46864_14041_41214_05150;
    localparam logic [19:0] FLOW_LEVEL  = 20'h1247C;
    localparam logic [19:0] PULSE_LEVEL = 20'h137C5;

    localparam int IDLE_PERCENT = 21;
    localparam int RANDOM_ITEMS = 440;
    localparam int TAIL_CYCLES  = 60;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    lea_pkg::req_t req_data = '0;
    logic          pix_valid;
    logic          pix_stall = 1'b0;
    lea_pkg::pix_t pix_data;

    lea_pkg::req_t pending_reqs[$];
    lea_pkg::pix_t expected_pixels[$];
    int    issued = 0;
    int    accepted = 0;
    int    total_reqs = 0;
    int    error_count = 0;
    logic  calm;

    // Predicted animator state
    logic        fx_running = 1'b0;
    logic        fx_blank_done = 1'b0;
    logic [31:0] fx_start = '0;
    logic [31:0] fx_last_frame = '1;
    logic [1:0]  fx_kind = lea_pkg::EFFECT_NONE;
    logic        fx_right = 1'b0;
    logic [7:0]  fx_red = '0;
    logic [7:0]  fx_green = '0;
    logic [7:0]  fx_blue = '0;
    logic [15:0] fx_length = '0;
    logic [15:0] fx_period = '0;

    led_effect_animator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data)
    );

    always #2 clk = ~clk;

    // No idling on either side for this stretch of requests.
    assign calm = (issued >= 200) && (issued < 300);

    task automatic push_pixel(input int idx, input int num, input int den);
        lea_pkg::pix_t p;
        p.pixel_index = 3'(idx);
        p.out_red     = (den == 0) ? 8'd0 : 8'((int'(fx_red) * num) / den);
        p.out_green   = (den == 0) ? 8'd0 : 8'((int'(fx_green) * num) / den);
        p.out_blue    = (den == 0) ? 8'd0 : 8'((int'(fx_blue) * num) / den);
        p.last        = (idx == int'(lea_pkg::LAST_PIX));
        expected_pixels.push_back(p);
    endtask

    task automatic push_black_frame();
        for (int i = 0; i < int'(lea_pkg::NPIX); i++)
        begin
            push_pixel(i, 0, 0);
        end
    endtask

    task automatic predict_frame(input lea_pkg::req_t rq);
        logic [31:0] elapsed;
        logic [31:0] frame;
        int          ph;
        int          off;
        int          head;
        int          gap;
        int          lvl;
        int          npix;
        npix = int'(lea_pkg::NPIX);
        if (rq.req_type == lea_pkg::REQ_START)
        begin
            fx_kind       = rq.effect;
            fx_right      = rq.to_right;
            fx_red        = rq.red;
            fx_green      = rq.green;
            fx_blue       = rq.blue;
            fx_length     = rq.span_ms;
            fx_period     = rq.interval_ms;
            fx_start      = rq.now_ms;
            fx_last_frame = '1;
            fx_running    = rq.enable && (rq.interval_ms != 16'd0) && (rq.span_ms != 16'd0);
            fx_blank_done = 1'b0;
        end
        else if (!fx_running)
        begin
            // Blank once, then stay silent until the next start.
            if (!fx_blank_done)
            begin
                fx_blank_done = 1'b1;
                push_black_frame();
            end
        end
        else
        begin
            elapsed = rq.now_ms - fx_start;
            if (elapsed >= {16'd0, fx_length})
            begin
                fx_running    = 1'b0;
                fx_blank_done = 1'b1;
                push_black_frame();
            end
            else
            begin
                frame = elapsed / {16'd0, fx_period};
                if (frame != fx_last_frame)
                begin
                    fx_last_frame = frame;
                    ph   = int'(frame % 32'd4);
                    off  = int'(frame % 32'd5);
                    head = fx_right ? off : (npix - 1) - off;
                    lvl  = int'(PULSE_LEVEL[off * 4 +: 4]);
                    for (int i = 0; i < npix; i++)
                    begin
                        case (fx_kind)
                            lea_pkg::EFFECT_RIPPLE:
                                push_pixel(i, 1, int'(RIPPLE_DEN[(ph * 5 + i) * 4 +: 4]));
                            lea_pkg::EFFECT_FLOW:
                            begin
                                gap = fx_right ? (head + npix - i) % npix
                                               : (i + npix - head) % npix;
                                push_pixel(i, int'(FLOW_LEVEL[gap * 4 +: 4]),
                                           int'(lea_pkg::DEN_TWELFTHS));
                            end
                            lea_pkg::EFFECT_PULSE:
                                push_pixel(i, (i == int'(lea_pkg::MID_PIX)) ? lvl
                                                                           : (lvl * 2) / 3,
                                           int'(lea_pkg::DEN_TWELFTHS));
                            default:
                                push_pixel(i, 0, 0);
                        endcase
                    end
                end
            end
        end
    endtask

    task automatic add_start(input logic [31:0] t, input logic en, input logic [1:0] eff,
                             input logic right, input logic [23:0] rgb,
                             input logic [15:0] dur, input logic [15:0] intv);
        lea_pkg::req_t rq;
        rq.req_type    = lea_pkg::REQ_START;
        rq.now_ms      = t;
        rq.enable      = en;
        rq.effect      = eff;
        rq.to_right    = right;
        rq.red         = rgb[23:16];
        rq.green       = rgb[15:8];
        rq.blue        = rgb[7:0];
        rq.span_ms     = dur;
        rq.interval_ms = intv;
        pending_reqs.push_back(rq);
    endtask

    task automatic add_tick(input logic [31:0] t);
        logic [95:0]   noise;
        lea_pkg::req_t rq;
        // Fill the fields a tick ignores with junk.
        noise = {$urandom, $urandom, $urandom};
        rq = noise[$bits(lea_pkg::req_t)-1:0];
        rq.req_type = lea_pkg::REQ_TICK;
        rq.now_ms   = t;
        pending_reqs.push_back(rq);
    endtask

    // Check pixels before predicting, so a stray pixel never matches a new frame.
    always @(posedge clk)
    begin : pixel_monitor
        lea_pkg::pix_t want;
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, pix_data);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (want !== pix_data)
                begin
                    $display("%0t: pixel mismatch, expected %h, actual %h",
                             $time, want, pix_data);
                    error_count++;
                end
            end
        end
        if (rst_n && req_valid && !req_stall)
        begin
            predict_frame(req_data);
            accepted++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // Hold the payload until the transaction is taken.
            if (accepted == issued)
            begin
                if (pending_reqs.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    req_data  <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    issued++;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            pix_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    initial
    begin
        #2_000_000;
        $display("led_effect_animator regression: fail");
        $finish;
    end

    initial
    begin
        logic [31:0] t0;
        logic [31:0] ofs;
        logic [15:0] dur;
        logic [15:0] intv;
        int          kind;
        int          nticks;
        int          target;

        // Blank after reset, then silence.
        add_tick(32'd5);
        add_tick(32'd6);
        // Starts that cannot run: disabled, zero duration, zero interval.
        add_start(32'd100, 1'b0, lea_pkg::EFFECT_RIPPLE, 1'b0, 24'hFFFFFF, 16'd10, 16'd1);
        add_tick(32'd101);
        add_start(32'd200, 1'b1, lea_pkg::EFFECT_RIPPLE, 1'b0, 24'hFFFFFF, 16'd0, 16'd5);
        add_tick(32'd201);
        add_start(32'd300, 1'b1, lea_pkg::EFFECT_FLOW, 1'b1, 24'hFF8001, 16'd10, 16'd0);
        add_tick(32'd301);
        // Ripple through all four phases, a repeated frame, then the end.
        add_start(32'd1000, 1'b1, lea_pkg::EFFECT_RIPPLE, 1'b0, 24'hFFFFFF, 16'd10, 16'd1);
        for (int k = 0; k < 4; k++)
        begin
            add_tick(32'd1000 + 32'(k));
        end
        add_tick(32'd1003);
        add_tick(32'd1010);
        add_tick(32'd1011);
        add_start(32'd2000, 1'b1, lea_pkg::EFFECT_FLOW, 1'b1, 24'hFFFFFF, 16'd100, 16'd2);
        add_tick(32'd2002);
        add_start(32'd3000, 1'b1, lea_pkg::EFFECT_FLOW, 1'b0, 24'h8040C0, 16'd100, 16'd1);
        add_tick(32'd3003);
        add_start(32'd4000, 1'b1, lea_pkg::EFFECT_PULSE, 1'b0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        add_tick(32'd4000);
        add_tick(32'd4000 + 32'hFFFE);
        add_tick(32'd4000 + 32'hFFFF);
        add_start(32'd5000, 1'b1, lea_pkg::EFFECT_NONE, 1'b1, 24'h123456, 16'd50, 16'd5);
        add_tick(32'd5007);
        // Tick before the start time ends the effect.
        add_start(32'd6000, 1'b1, lea_pkg::EFFECT_PULSE, 1'b0, 24'hFFFFFF, 16'd100, 16'd1);
        add_tick(32'd5999);
        // Elapsed time across the 32-bit wrap.
        add_start(32'hFFFF_FFF0, 1'b1, lea_pkg::EFFECT_FLOW, 1'b1, 24'hA5A5A5, 16'd64, 16'd4);
        add_tick(32'h0000_0005);

        target = pending_reqs.size() + RANDOM_ITEMS;
        while (pending_reqs.size() < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                t0   = $urandom;
                dur  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(1, 120));
                intv = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(1, 12));
                add_start(t0, 1'b1, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          24'($urandom), dur, intv);
                ofs    = '0;
                nticks = $urandom_range(3, 12);
                repeat (nticks)
                begin
                    add_tick(t0 + ofs);
                    ofs = ofs + $urandom_range(0, 2 * intv + dur / 4);
                end
            end
            else if (kind < 90)
            begin
                add_start($urandom, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 24'($urandom),
                          ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)),
                          ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
            end
            else
            begin
                add_tick($urandom);
            end
        end
        total_reqs = pending_reqs.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted != total_reqs || expected_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("led_effect_animator regression: pass");
        end
        else
        begin
            $display("led_effect_animator regression: fail");
        end
        $finish;
    end

endmodule
